// ----- rtl/core/ackrf_pkg.sv -----
// shared types and constants for the ack response frame receiver
`timescale 1ns / 1ps
`default_nettype none

package ackrf_pkg;

  localparam logic [7:0] ACK_BYTE     = 8'h06;
  localparam logic [7:0] NAK_BYTE     = 8'h15;
  localparam logic [7:0] CSFAIL_BYTE  = 8'h51;
  localparam logic [7:0] LEN_OVERHEAD = 8'd3;

  typedef enum logic [1:0] {
    KIND_START    = 2'd0,
    KIND_BYTE     = 2'd1,
    KIND_LINK_ERR = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    PH_HEADER   = 2'd0,
    PH_LENGTH   = 2'd1,
    PH_DATA     = 2'd2,
    PH_CHECKSUM = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_BUSY     = 2'd0,
    ST_COMPLETE = 2'd1,
    ST_FAIL     = 2'd2,
    ST_CSFAIL   = 2'd3
  } status_t;

  typedef struct packed {
    phase_t     phase;
    logic [7:0] running_sum;
    logic [7:0] remaining_count;
    logic       data_expected;
    logic [7:0] byte_position;
  } parse_state_t;

  typedef struct packed {
    kind_t      kind;
    logic       expect_data;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    status_t    status;
    logic       data_valid;
    logic [7:0] data_byte;
    logic [7:0] data_index;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/core/ackrf_parser.sv -----
// next-state and result logic of the response deframer
`timescale 1ns / 1ps
`default_nettype none

module ackrf_parser (
  input  ackrf_pkg::item_t        item,
  input  ackrf_pkg::parse_state_t state,
  output ackrf_pkg::parse_state_t state_nxt,
  output ackrf_pkg::result_t      res_nxt
);

  logic [7:0] sum_add;
  logic [7:0] rem_dec;

  assign sum_add = state.running_sum + item.rx_byte;
  assign rem_dec = state.remaining_count - 8'd1;

  always_comb begin
    state_nxt          = state;
    res_nxt.status     = ackrf_pkg::ST_BUSY;
    res_nxt.data_valid = 1'b0;
    res_nxt.data_byte  = 8'd0;
    res_nxt.data_index = 8'd0;
    case (item.kind)
      ackrf_pkg::KIND_START: begin
        state_nxt.phase           = ackrf_pkg::PH_HEADER;
        state_nxt.running_sum     = 8'd0;
        state_nxt.remaining_count = 8'd0;
        state_nxt.byte_position   = 8'd0;
        state_nxt.data_expected   = item.expect_data;
      end
      ackrf_pkg::KIND_LINK_ERR: begin
        state_nxt.phase = ackrf_pkg::PH_HEADER;
        res_nxt.status  = ackrf_pkg::ST_FAIL;
      end
      ackrf_pkg::KIND_BYTE: begin
        case (state.phase)
          ackrf_pkg::PH_HEADER: begin
            state_nxt.running_sum = item.rx_byte;
            if (item.rx_byte == ackrf_pkg::NAK_BYTE) begin
              res_nxt.status = ackrf_pkg::ST_FAIL;
            end else if (item.rx_byte == ackrf_pkg::CSFAIL_BYTE) begin
              res_nxt.status = ackrf_pkg::ST_CSFAIL;
            end else if (item.rx_byte == ackrf_pkg::ACK_BYTE) begin
              if (state.data_expected) begin
                state_nxt.phase = ackrf_pkg::PH_LENGTH;
              end else begin
                res_nxt.status = ackrf_pkg::ST_COMPLETE;
              end
            end
          end
          ackrf_pkg::PH_LENGTH: begin
            state_nxt.remaining_count = item.rx_byte;
            state_nxt.running_sum     = sum_add;
            state_nxt.byte_position   = 8'd0;
            state_nxt.phase = (item.rx_byte <= ackrf_pkg::LEN_OVERHEAD) ?
                              ackrf_pkg::PH_CHECKSUM : ackrf_pkg::PH_DATA;
          end
          ackrf_pkg::PH_DATA: begin
            state_nxt.running_sum     = sum_add;
            state_nxt.remaining_count = rem_dec;
            state_nxt.byte_position   = state.byte_position + 8'd1;
            res_nxt.data_valid        = 1'b1;
            res_nxt.data_byte         = item.rx_byte;
            res_nxt.data_index        = state.byte_position;
            if (rem_dec <= ackrf_pkg::LEN_OVERHEAD) begin
              state_nxt.phase = ackrf_pkg::PH_CHECKSUM;
            end
          end
          default: begin
            state_nxt.phase = ackrf_pkg::PH_HEADER;
            res_nxt.status  = (item.rx_byte == state.running_sum) ?
                              ackrf_pkg::ST_COMPLETE : ackrf_pkg::ST_FAIL;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/core/ack_response_frame_receiver.sv -----
// top level of the ack response frame receiver
//
//   port group  dir  contents
//   in_*        in   tuser: kind; tdata: expect_data, rx_byte
//   out_*       out  tuser: data_valid; tdata: status, data_byte, data_index
//
// one transaction per cycle sustained while out_tready stays high
// an input register feeds the parser, whose result lands in an output register
// the parser state advances only when the input register moves to the output
// a stall on the output holds both registers and drops in_tready only when full
// reset clears valids and returns the parser to header hunt
`timescale 1ns / 1ps
`default_nettype none

module ack_response_frame_receiver (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // expect_data, rx_byte, zero pad
  input  logic [1:0]  in_tuser,   // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // status, data_byte, data_index, zero pad
  output logic        out_tuser   // data_valid
);

  ackrf_pkg::item_t        item_r;
  logic                    item_valid_r;
  ackrf_pkg::result_t      res_r;
  ackrf_pkg::result_t      res_nxt;
  logic                    out_valid_r;
  ackrf_pkg::parse_state_t state_r;
  ackrf_pkg::parse_state_t state_nxt;
  logic                    adv;
  logic                    in_fire;

  assign adv       = item_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !item_valid_r || adv;
  assign in_fire   = in_tvalid && in_tready;

  ackrf_parser u_parser (
    .item      (item_r),
    .state     (state_r),
    .state_nxt (state_nxt),
    .res_nxt   (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r          <= 1'b0;
      out_valid_r           <= 1'b0;
      state_r.phase         <= ackrf_pkg::PH_HEADER;
      state_r.running_sum   <= 8'd0;
      state_r.remaining_count <= 8'd0;
      state_r.data_expected <= 1'b0;
      state_r.byte_position <= 8'd0;
    end else begin
      if (in_fire) begin
        item_valid_r <= 1'b1;
      end else if (adv) begin
        item_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r.kind        <= ackrf_pkg::kind_t'(in_tuser);
      item_r.expect_data <= in_tdata[0];
      item_r.rx_byte     <= in_tdata[8:1];
    end
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_r.data_valid;
  assign out_tdata  = {6'd0, res_r.data_index, res_r.data_byte, res_r.status};

endmodule

`default_nettype wire
